>>> src/led_strip_mirror_remap_macros.svh
// Assertion macros shared by the led strip mirror remap RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef LED_STRIP_MIRROR_REMAP_MACROS_SVH
`define LED_STRIP_MIRROR_REMAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSMR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lsmr_pkg.sv
// Shared types and constants for the led strip mirror remap block.
// Has no dependencies; used by lsmr_remap and led_strip_mirror_remap.
`timescale 1ns / 1ps

package lsmr_pkg;

    localparam int MAX_PIXELS_DEFAULT = 256;

    localparam int MODE_W = 3;
    localparam int LEN_W  = 9;
    localparam int POS_W  = 8;
    localparam int PIX_W  = 24;
    localparam int CFG_W  = 9;

    localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE        = 3'd0,
        MODE_REVERSE     = 3'd1,
        MODE_CENTRE      = 3'd2,
        MODE_EDGE        = 3'd3,
        MODE_REPEAT      = 3'd4,
        MODE_REPEAT_REV  = 3'd5
    } mode_t;

    typedef enum logic [0:0] {
        REG_MODE         = 1'b0,
        REG_STRIP_LENGTH = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } opcode_t;

endpackage

>>> src/lsmr_remap.sv
// Address remap for mirrored readout: maps an output position to a frame index.
// Depends on lsmr_pkg.
`timescale 1ns / 1ps

module lsmr_remap #(
    parameter int MAX_PIXELS = lsmr_pkg::MAX_PIXELS_DEFAULT,
    parameter int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
    input  logic [lsmr_pkg::MODE_W-1:0] mode,
    input  logic [lsmr_pkg::LEN_W-1:0]  strip_length,
    input  logic [lsmr_pkg::POS_W-1:0]  position,
    output logic [AW-1:0]               frame_index,
    output logic                        out_of_range
);
    import lsmr_pkg::*;

    localparam int CW0 = $clog2(MAX_PIXELS + 1) + 1;
    localparam int CW  = (CW0 > 10) ? CW0 : 10;

    logic [CW-1:0] len_ext;
    logic [CW-1:0] n;
    logic [CW-1:0] m;
    logic [CW-1:0] c;
    logic [CW-1:0] off;
    logic [CW-1:0] p;
    logic [CW-1:0] idx;
    logic          upper;

    always_comb
    begin
        len_ext = CW'(strip_length);
        n       = (len_ext > CW'(MAX_PIXELS)) ? CW'(MAX_PIXELS) : len_ext;
        m       = (n >> 1) + CW'(n[0]);
        c       = m - CW'(1);
        off     = n[0] ? '0 : CW'(1);
        p       = CW'(position);
        upper   = (p >= c + off);
        case (mode)
            MODE_REVERSE:    idx = n - CW'(1) - p;
            MODE_CENTRE:     idx = upper ? (c - (p - c - off)) : p;
            MODE_EDGE:       idx = upper ? (p - c - off) : (c - p);
            MODE_REPEAT:     idx = upper ? (p - c - off) : p;
            MODE_REPEAT_REV: idx = (p < m) ? (m - CW'(1) - p) : ((m << 1) - CW'(1) - p);
            default:         idx = p;
        endcase
        out_of_range = (p >= n);
        frame_index  = idx[AW-1:0];
    end

endmodule

>>> src/led_strip_mirror_remap.sv
// Top level of the led strip mirror remap block: frame memory, config and handshake.
// Depends on lsmr_pkg, lsmr_remap and led_strip_mirror_remap_macros.svh.
`timescale 1ns / 1ps
//
// The block keeps one frame of 24-bit RGB pixels in a synchronous memory of
// MAX_PIXELS entries. Input words arrive on in_valid/in_stall with an opcode,
// a position and a pixel. A write word stores the pixel and gives no result;
// a position at or above MAX_PIXELS is ignored. A read word remaps the
// position by the configured mirror mode and strip length, reads the memory
// and returns one result word on out_valid/out_stall.
// A read result appears in the cycle after the read is accepted, since the
// frame memory read is registered. One word is taken per cycle while the
// output side does not stall. The result register doubles as the memory
// read register, so while a result waits under out_stall the input side
// stalls. The write port (cfg_we, cfg_index, cfg_data) sets mode and strip
// length and must be used only while idle; the block does not enforce it.
// Reset clears the result valid flag and sets mode to none and the strip
// length to 256; the frame memory is not cleared and must be written
// before it is read.
//
module led_strip_mirror_remap #(
    parameter int MAX_PIXELS = lsmr_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  lsmr_pkg::cfg_index_t          cfg_index,
    input  logic [lsmr_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic [lsmr_pkg::POS_W-1:0]    position,
    input  logic [lsmr_pkg::PIX_W-1:0]    pixel_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lsmr_pkg::PIX_W-1:0]    pixel_out,
    output logic                          out_of_range
);
    import lsmr_pkg::*;

    `include "led_strip_mirror_remap_macros.svh"

    localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int PW  = (AW + 1 > POS_W + 1) ? AW + 1 : POS_W + 1;

    logic [PIX_W-1:0]  frame_mem [MAX_PIXELS];

    logic [MODE_W-1:0] mode_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              valid_reg;
    logic              valid_next;
    logic              oor_reg;
    logic [PIX_W-1:0]  rd_data_reg;

    logic [AW-1:0]     frame_index;
    logic              read_oor;
    logic              accept;
    logic              do_write;
    logic              do_read;

    lsmr_remap #(
        .MAX_PIXELS (MAX_PIXELS),
        .AW         (AW)
    ) u_remap (
        .mode         (mode_reg),
        .strip_length (len_reg),
        .position     (position),
        .frame_index  (frame_index),
        .out_of_range (read_oor)
    );

    always_comb
    begin
        in_stall   = valid_reg && out_stall;
        accept     = in_valid && !in_stall;
        do_write   = accept && (opcode == OP_WRITE)
                     && (PW'(position) < PW'(MAX_PIXELS));
        do_read    = accept && (opcode == OP_READ);
        valid_next = do_read || (valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NONE;
            len_reg   <= LEN_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:         mode_reg <= cfg_data[MODE_W-1:0];
                    REG_STRIP_LENGTH: len_reg  <= cfg_data[LEN_W-1:0];
                    default:          mode_reg <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            frame_mem[AW'(position)] <= pixel_in;
        end
        if (do_read)
        begin
            rd_data_reg <= frame_mem[frame_index];
            oor_reg     <= read_oor;
        end
    end

    always_comb
    begin
        out_valid    = valid_reg;
        out_of_range = oor_reg;
        pixel_out    = oor_reg ? '0 : rd_data_reg;
    end

    `LSMR_ASSERT_NEXT(a_read_gives_result, do_read, valid_reg,
                      "accepted read did not produce a result word")
    `LSMR_ASSERT_NEXT(a_write_gives_none, accept && (opcode == OP_WRITE), !valid_reg,
                      "accepted write produced a result word")
    `LSMR_ASSERT_SAME(a_oor_zero, out_valid && out_of_range, pixel_out == '0,
                      "out of range result carries a nonzero pixel")

endmodule
